// File: rtl/ndkt_pkg.sv
package ndkt_pkg;

  localparam int unsigned DirEntriesDef = 16;
  localparam int unsigned NameChars     = 8;
  localparam int unsigned KeyW          = 64;
  localparam int unsigned InodeW        = 16;
  localparam int unsigned IndexOutW     = 4;
  localparam int unsigned CountOutW     = 5;

  typedef enum logic [1:0] {
    CmdFind   = 2'd0,
    CmdAdd    = 2'd1,
    CmdRemove = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StNotFound = 2'd1,
    StPresent  = 2'd2,
    StFull     = 2'd3
  } status_e;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

// File: rtl/ndkt_cell.sv
module ndkt_cell (
  input  logic                                  clk_i,
  input  logic                                  cmp_en_i,
  input  logic [ndkt_pkg::KeyW-1:0]             cmp_key_i,
  input  logic                                  live_i,
  input  ndkt_pkg::cell_ctl_t                   ctl_i,
  input  logic [ndkt_pkg::KeyW-1:0]             wr_name_i,
  input  logic [ndkt_pkg::InodeW-1:0]           wr_inode_i,
  input  logic [ndkt_pkg::KeyW-1:0]             next_name_i,
  input  logic [ndkt_pkg::InodeW-1:0]           next_inode_i,
  output logic [ndkt_pkg::KeyW-1:0]             name_o,
  output logic [ndkt_pkg::InodeW-1:0]           inode_o,
  output logic                                  match_o
);
  import ndkt_pkg::*;

  logic [KeyW-1:0]   name_q;
  logic [InodeW-1:0] inode_q;
  logic              match_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      name_q  <= wr_name_i;
      inode_q <= wr_inode_i;
    end else if (ctl_i.shift) begin
      name_q  <= next_name_i;
      inode_q <= next_inode_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmp_en_i) begin
      match_q <= live_i && (name_q == cmp_key_i);
    end
  end

  assign name_o  = name_q;
  assign inode_o = inode_q;
  assign match_o = match_q;

endmodule

// File: rtl/name_keyed_directory_table.sv
// Channel  | Handshake                | Word
// ---------+--------------------------+------------------------------------------
// in       | in_valid_i / in_ready_o  | command_i, name_key_i, inode_number_i
// out      | out_valid_o / out_ready_i| status_o, found_inode_o, entry_index_o,
//          |                          | entry_count_o
//
// Every cell compares its entry with the key at the accept edge; a resolve step
// then resolves the single match, updates the cell row and loads the output
// register. A new command is taken while a result waits.
// The resolve cycle holds while the output register is full and not taken.
// Reset empties the table at once; entry storage itself is not cleared.
module name_keyed_directory_table #(
  parameter int unsigned DirEntries = ndkt_pkg::DirEntriesDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [1:0]                            command_i,
  input  logic [ndkt_pkg::KeyW-1:0]             name_key_i,
  input  logic [ndkt_pkg::InodeW-1:0]           inode_number_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [1:0]                            status_o,
  output logic [ndkt_pkg::InodeW-1:0]           found_inode_o,
  output logic [ndkt_pkg::IndexOutW-1:0]        entry_index_o,
  output logic [ndkt_pkg::CountOutW-1:0]        entry_count_o
);
  import ndkt_pkg::*;

  localparam int unsigned IdxW = (DirEntries > 1) ? $clog2(DirEntries) : 1;
  localparam int unsigned CntW = $clog2(DirEntries + 1);

  function automatic logic [KeyW-1:0] norm_key(logic [KeyW-1:0] key);
    logic [KeyW-1:0] res;
    logic            alive;
    res   = '0;
    alive = 1'b1;
    for (int b = 0; b < 8; b++) begin
      if (alive && (b < NameChars) && (key[8*b +: 8] != 8'd0)) begin
        res[8*b +: 8] = key[8*b +: 8];
      end else begin
        alive = 1'b0;
      end
    end
    return res;
  endfunction

  logic              busy_q;
  cmd_e              cmd_q;
  logic [KeyW-1:0]   key_q;
  logic [InodeW-1:0] inode_q;
  logic [CntW-1:0]   count_q, count_d;
  logic              out_valid_q;
  status_e           status_q, status_d;
  logic [InodeW-1:0] found_q, found_d;
  logic [IdxW-1:0]   index_q, index_d;

  logic                  accept;
  logic                  fire;
  logic [KeyW-1:0]       in_key;
  logic                  hit;
  logic [IdxW-1:0]       hit_pos;
  logic [InodeW-1:0]     hit_inode;
  logic                  add_do;
  logic                  rem_do;
  logic [DirEntries-1:0] match;
  logic [DirEntries-1:0] live;
  cell_ctl_t             ctl [DirEntries];
  logic [KeyW-1:0]       cell_name  [DirEntries];
  logic [InodeW-1:0]     cell_inode [DirEntries];
  logic [IdxW+IndexOutW-1:0] index_wide;
  logic [CntW+CountOutW-1:0] count_wide;

  assign in_ready_o = !busy_q;
  assign accept     = in_valid_i && in_ready_o;
  assign fire       = busy_q && (!out_valid_q || out_ready_i);
  assign in_key     = norm_key(name_key_i);

  always_comb begin
    hit       = 1'b0;
    hit_pos   = '0;
    hit_inode = '0;
    for (int i = 0; i < DirEntries; i++) begin
      hit       = hit | match[i];
      hit_pos   = hit_pos | (match[i] ? IdxW'(i) : '0);
      hit_inode = hit_inode | (match[i] ? cell_inode[i] : '0);
    end
  end

  always_comb begin
    status_d = StNotFound;
    found_d  = '0;
    index_d  = '0;
    count_d  = count_q;
    add_do   = 1'b0;
    rem_do   = 1'b0;
    unique case (cmd_q)
      CmdFind: begin
        if (hit) begin
          status_d = StOk;
          found_d  = hit_inode;
          index_d  = hit_pos;
        end
      end
      CmdAdd: begin
        if (hit) begin
          status_d = StPresent;
          index_d  = hit_pos;
        end else if (count_q == CntW'(DirEntries)) begin
          status_d = StFull;
        end else begin
          status_d = StOk;
          index_d  = count_q[IdxW-1:0];
          count_d  = count_q + CntW'(1);
          add_do   = 1'b1;
        end
      end
      CmdRemove: begin
        if (hit) begin
          status_d = StOk;
          index_d  = hit_pos;
          count_d  = count_q - CntW'(1);
          rem_do   = 1'b1;
        end
      end
      default: begin
        status_d = StNotFound;
      end
    endcase
  end

  for (genvar g = 0; g < DirEntries; g++) begin : g_cell
    logic [KeyW-1:0]   nxt_name;
    logic [InodeW-1:0] nxt_inode;

    if (g == DirEntries - 1) begin : g_last
      assign nxt_name  = '0;
      assign nxt_inode = '0;
    end else begin : g_mid
      assign nxt_name  = cell_name[g+1];
      assign nxt_inode = cell_inode[g+1];
    end

    assign live[g]      = CntW'(g) < count_q;
    assign ctl[g].load  = fire && add_do && (count_q == CntW'(g));
    assign ctl[g].shift = fire && rem_do && (IdxW'(g) >= hit_pos);

    ndkt_cell u_cell (
      .clk_i        (clk_i),
      .cmp_en_i     (accept),
      .cmp_key_i    (in_key),
      .live_i       (live[g]),
      .ctl_i        (ctl[g]),
      .wr_name_i    (key_q),
      .wr_inode_i   (inode_q),
      .next_name_i  (nxt_name),
      .next_inode_i (nxt_inode),
      .name_o       (cell_name[g]),
      .inode_o      (cell_inode[g]),
      .match_o      (match[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (fire) begin
        busy_q <= 1'b0;
      end
      if (fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_e'(command_i);
      key_q   <= in_key;
      inode_q <= inode_number_i;
    end
    if (fire) begin
      status_q <= status_d;
      found_q  <= found_d;
      index_q  <= index_d;
    end
  end

  assign index_wide    = {{IndexOutW{1'b0}}, index_q};
  assign count_wide    = {{CountOutW{1'b0}}, count_q};
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign found_inode_o = found_q;
  assign entry_index_o = index_wide[IndexOutW-1:0];
  assign entry_count_o = count_wide[CountOutW-1:0];

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DirEntries))
    else $error("entry count above table size");

  a_single_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> $onehot0(match))
    else $error("more than one cell matches the key");

  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> (count_q == $past(count_q)) || (count_q == $past(count_q) + CntW'(1)) ||
             (count_q == $past(count_q) - CntW'(1)))
    else $error("entry count moved by more than one");

  a_count_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(count_q))
    else $error("entry count changed outside resolve");

  a_full_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == StFull)) |-> (count_q == CntW'(DirEntries)))
    else $error("full status with room left");

endmodule

// File: verif/name_keyed_directory_table_test.sv
module name_keyed_directory_table_test;
  import ndkt_pkg::*;

  localparam int unsigned Entries = DirEntriesDef;
  localparam logic [1:0] CmdUnused = 2'd3;
  localparam int unsigned PoolSize = 24;
  localparam int unsigned NumRandom = 1700;
  localparam int unsigned HoldCycles = 120;

  typedef struct packed {
    status_e                 status;
    logic [InodeW-1:0]       inode;
    logic [IndexOutW-1:0]    index;
    logic [CountOutW-1:0]    count;
  } dir_result_t;

  typedef struct {
    logic [1:0]              cmd;
    logic [KeyW-1:0]         key;
    logic [InodeW-1:0]       inode;
    bit                      typed;
    dir_result_t             want;
  } dir_step_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [1:0]            command_i = CmdFind;
  logic [KeyW-1:0]       name_key_i = '0;
  logic [InodeW-1:0]     inode_number_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [1:0]            status_o;
  logic [InodeW-1:0]     found_inode_o;
  logic [IndexOutW-1:0]  entry_index_o;
  logic [CountOutW-1:0]  entry_count_o;

  name_keyed_directory_table uut (.*);

  always #2 clk_i = ~clk_i;

  logic [KeyW-1:0]   dir_names  [Entries];
  logic [InodeW-1:0] dir_inodes [Entries];
  int unsigned       dir_used;

  dir_result_t dir_expected [$];
  int unsigned words_accepted;
  int unsigned mismatches;

  logic [KeyW-1:0] pool_names [PoolSize];
  int unsigned     pool_lens  [PoolSize];

  function automatic logic [KeyW-1:0] dir_name_of(logic [KeyW-1:0] key);
    logic [KeyW-1:0] name;
    name = '0;
    for (int i = 0; i < NameChars; i++) begin
      if (key[8*i +: 8] == 8'h00) break;
      name[8*i +: 8] = key[8*i +: 8];
    end
    return name;
  endfunction

  function automatic dir_result_t dir_apply(logic [1:0] cmd, logic [KeyW-1:0] key,
                                            logic [InodeW-1:0] inode);
    dir_result_t r;
    logic [KeyW-1:0] name;
    int hit_pos;
    name = dir_name_of(key);
    hit_pos = -1;
    for (int i = 0; i < dir_used; i++) begin
      if (dir_names[i] == name) begin
        hit_pos = i;
        break;
      end
    end
    r.status = StNotFound;
    r.inode = '0;
    r.index = '0;
    case (cmd)
      CmdFind: begin
        if (hit_pos >= 0) begin
          r.status = StOk;
          r.inode = dir_inodes[hit_pos];
          r.index = hit_pos[IndexOutW-1:0];
        end
      end
      CmdAdd: begin
        if (hit_pos >= 0) begin
          r.status = StPresent;
          r.index = hit_pos[IndexOutW-1:0];
        end else if (dir_used >= Entries) begin
          r.status = StFull;
        end else begin
          dir_names[dir_used] = name;
          dir_inodes[dir_used] = inode;
          r.index = dir_used[IndexOutW-1:0];
          dir_used++;
          r.status = StOk;
        end
      end
      CmdRemove: begin
        if (hit_pos >= 0) begin
          for (int i = hit_pos; i + 1 < dir_used; i++) begin
            dir_names[i] = dir_names[i+1];
            dir_inodes[i] = dir_inodes[i+1];
          end
          dir_used--;
          r.index = hit_pos[IndexOutW-1:0];
          r.status = StOk;
        end
      end
      default: ;
    endcase
    r.count = dir_used[CountOutW-1:0];
    return r;
  endfunction

  // call at a falling edge; returns at the falling edge after the accept
  task automatic send_word(logic [1:0] cmd, logic [KeyW-1:0] key,
                           logic [InodeW-1:0] inode, bit typed, dir_result_t want);
    dir_result_t got;
    in_valid_i <= 1'b1;
    command_i <= cmd;
    name_key_i <= key;
    inode_number_i <= inode;
    do @(posedge clk_i); while (!in_ready_o);
    got = dir_apply(cmd, key, inode);
    dir_expected.push_back(typed ? want : got);
    words_accepted++;
    @(negedge clk_i);
  endtask

  function automatic void pool_refresh(int unsigned p);
    pool_lens[p] = $urandom_range(0, NameChars);
    pool_names[p] = '0;
    for (int i = 0; i < pool_lens[p]; i++) pool_names[p][8*i +: 8] = 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [KeyW-1:0] pool_key(int unsigned p);
    logic [KeyW-1:0] key;
    key = pool_names[p];
    if (pool_lens[p] < NameChars && $urandom_range(0, 1)) begin
      for (int i = pool_lens[p] + 1; i < 8; i++) key[8*i +: 8] = 8'($urandom_range(0, 255));
    end
    return key;
  endfunction

  always @(posedge clk_i) begin
    dir_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (dir_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: status %0d inode %h index %0d count %0d",
                   status_o, found_inode_o, entry_index_o, entry_count_o);
      end else begin
        want = dir_expected.pop_front();
        if (status_o !== want.status || found_inode_o !== want.inode ||
            entry_index_o !== want.index || entry_count_o !== want.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status %0d inode %h index %0d count %0d, %s",
                     want.status, want.inode, want.index, want.count,
                     $sformatf("got status %0d inode %h index %0d count %0d",
                               status_o, found_inode_o, entry_index_o, entry_count_o));
        end
      end
    end
  end

  initial begin
    int unsigned hold_at [2];
    int unsigned hold_idx;
    int unsigned mode;
    int unsigned span;
    int unsigned tick;
    hold_at[0] = 400;
    hold_at[1] = 1200;
    hold_idx = 0;
    tick = 0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 150);
      repeat (span) begin
        @(negedge clk_i);
        if (hold_idx < 2 && words_accepted >= hold_at[hold_idx]) begin
          out_ready_i <= 1'b0;
          repeat (HoldCycles) @(negedge clk_i);
          hold_idx++;
        end
        tick++;
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= ($urandom_range(0, 5) == 0);
          default: out_ready_i <= (tick % 4 != 0);
        endcase
      end
    end
  end

  initial begin
    dir_step_t dir_plan [$];
    dir_step_t row;
    int unsigned burst;
    int unsigned w_find, w_add, w_remove;
    int unsigned pick;
    logic [1:0] cmd;
    logic [KeyW-1:0] key;

    dir_used = 0;
    words_accepted = 0;
    mismatches = 0;

    dir_plan.push_back('{CmdFind, 64'h0, 16'h0, 1, '{StNotFound, 16'h0, 4'd0, 5'd0}});
    dir_plan.push_back('{CmdRemove, '1, 16'hFFFF, 1, '{StNotFound, 16'h0, 4'd0, 5'd0}});
    dir_plan.push_back('{CmdAdd, 64'h0, 16'hFFFF, 1, '{StOk, 16'h0, 4'd0, 5'd1}});
    dir_plan.push_back('{CmdFind, 64'hFFFF_FFFF_FFFF_FF00, 16'h0, 1,
                         '{StOk, 16'hFFFF, 4'd0, 5'd1}});
    dir_plan.push_back('{CmdAdd, '1, 16'h0, 1, '{StOk, 16'h0, 4'd1, 5'd2}});
    dir_plan.push_back('{CmdAdd, '1, 16'h1234, 1, '{StPresent, 16'h0, 4'd1, 5'd2}});
    dir_plan.push_back('{CmdUnused, '1, 16'hFFFF, 1, '{StNotFound, 16'h0, 4'd0, 5'd2}});
    dir_plan.push_back('{CmdAdd, 64'h00A5_0000_0063_6261, 16'h5A5A, 1,
                         '{StOk, 16'h0, 4'd2, 5'd3}});
    dir_plan.push_back('{CmdFind, 64'h0000_0000_0063_6261, 16'h0, 1,
                         '{StOk, 16'h5A5A, 4'd2, 5'd3}});
    dir_plan.push_back('{CmdRemove, 64'h1234_5678_9ABC_DE00, 16'h0, 1,
                         '{StOk, 16'h0, 4'd0, 5'd2}});
    dir_plan.push_back('{CmdFind, '1, 16'h0, 0, '0});
    dir_plan.push_back('{CmdFind, 64'h0000_0000_0063_6261, 16'h0, 0, '0});
    for (int i = 0; i < Entries - 2; i++) begin
      row.cmd = CmdAdd;
      row.key = {8{8'(i + 1)}};
      row.inode = 16'($urandom_range(0, 65535));
      row.typed = 0;
      row.want = '0;
      dir_plan.push_back(row);
    end
    dir_plan.push_back('{CmdAdd, 64'h7F, 16'h1, 1, '{StFull, 16'h0, 4'd0, 5'd16}});
    dir_plan.push_back('{CmdAdd, '1, 16'h2, 1, '{StPresent, 16'h0, 4'd0, 5'd16}});
    dir_plan.push_back('{CmdFind, {8{8'(Entries - 2)}}, 16'h0, 0, '0});
    dir_plan.push_back('{CmdRemove, '1, 16'h0, 0, '0});

    for (int p = 0; p < PoolSize; p++) pool_refresh(p);

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    burst = $urandom_range(1, 24);
    foreach (dir_plan[i]) begin
      send_word(dir_plan[i].cmd, dir_plan[i].key, dir_plan[i].inode,
                dir_plan[i].typed, dir_plan[i].want);
      burst--;
      if (burst == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
        burst = $urandom_range(1, 24);
      end
    end

    w_find = 40;
    w_add = 30;
    w_remove = 25;
    for (int n = 0; n < NumRandom; n++) begin
      if (n % 150 == 0) begin
        case ($urandom_range(0, 2))
          0: begin w_find = 30; w_add = 50; w_remove = 15; end
          1: begin w_find = 30; w_add = 15; w_remove = 50; end
          default: begin w_find = 40; w_add = 30; w_remove = 25; end
        endcase
        repeat (4) pool_refresh($urandom_range(0, PoolSize - 1));
      end
      pick = $urandom_range(0, 99);
      if (pick < w_find) cmd = CmdFind;
      else if (pick < w_find + w_add) cmd = CmdAdd;
      else if (pick < w_find + w_add + w_remove) cmd = CmdRemove;
      else cmd = CmdUnused;
      if ($urandom_range(0, 19) == 0) key = {$urandom, $urandom};
      else key = pool_key($urandom_range(0, PoolSize - 1));
      send_word(cmd, key, 16'($urandom_range(0, 65535)), 0, '0);
      burst--;
      if (burst == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
        burst = $urandom_range(1, 24);
      end
    end
    in_valid_i <= 1'b0;

    while (dir_expected.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && dir_expected.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule

// File: filelist.f
rtl/ndkt_pkg.sv
rtl/ndkt_cell.sv
rtl/name_keyed_directory_table.sv
verif/name_keyed_directory_table_test.sv
